@@ src/linear_probe_slot_map_defines.svh @@
// Assertion macros for the linear probe slot map checker.
// No dependencies; included by the checker file.
`ifndef LINEAR_PROBE_SLOT_MAP_DEFINES_SVH
`define LINEAR_PROBE_SLOT_MAP_DEFINES_SVH

// same-cycle implication
`define LPSM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("linear_probe_slot_map: same-cycle check failed");

// next-cycle implication
`define LPSM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("linear_probe_slot_map: next-cycle check failed");

`endif

@@ src/lpsm_pkg.sv @@
// Shared types, codes and defaults for the linear probe slot map.
// No dependencies; imported by every module of the block.
package lpsm_pkg;

    localparam int TABLE_ENTRIES_DEF = 4096;
    localparam int SLOT_LIMIT_DEF    = 4096;

    localparam int KEY_W    = 32;
    localparam int SLOT_W   = 12;
    localparam int USED_W   = 13;
    localparam int STAT_W   = 3;
    localparam int ACT_W    = 2;
    localparam int LIMIT_W  = 17;

    localparam logic [USED_W-1:0] MAX_SLOTS_RESET = 13'd4096;

    localparam logic [ACT_W-1:0] ACT_LOOKUP = 2'd0;
    localparam logic [ACT_W-1:0] ACT_INSERT = 2'd1;
    localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK        = 3'd0;
    localparam logic [STAT_W-1:0] STAT_ABSENT    = 3'd1;
    localparam logic [STAT_W-1:0] STAT_PRESENT   = 3'd2;
    localparam logic [STAT_W-1:0] STAT_EXHAUSTED = 3'd3;
    localparam logic [STAT_W-1:0] STAT_FULL      = 3'd4;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic [KEY_W-1:0] key;
    } t_in_item;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic [STAT_W-1:0] status;
    } t_out_item;

    typedef struct packed {
        logic              valid;
        logic [KEY_W-1:0]  key;
        logic [SLOT_W-1:0] slot;
    } t_entry;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_CLEAR
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
        logic sweep;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic resolved;
        logic last_probe;
        logic sweep_last;
    } t_dp_stat;

endpackage

@@ src/linear_probe_slot_map.sv @@
// Lookup/insert: each probe step reads one table entry and then checks it (one table
// read per probe); a new beat is taken in the cycle the result strobe shows.
// Clear: one entry swept per cycle over the memory port.
// Reset: synchronous, active low; then busy for a sweep over every entry that
// empties the table. Configuration writes are taken at any time.
// Depends on lpsm_pkg, lpsm_ctrl and lpsm_datapath.
module linear_probe_slot_map #(
    parameter int TABLE_ENTRIES = lpsm_pkg::TABLE_ENTRIES_DEF,
    parameter int SLOT_LIMIT    = lpsm_pkg::SLOT_LIMIT_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  lpsm_pkg::t_in_item  i_item,
    input  logic                i_cfg_we,
    input  logic [12:0]         i_cfg_wdata,
    output logic                o_strobe,
    output lpsm_pkg::t_out_item o_result
);
    import lpsm_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    lpsm_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_action (i_item.action),
        .i_stat   (stat),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    lpsm_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .SLOT_LIMIT    (SLOT_LIMIT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_strobe    (o_strobe),
        .o_result    (o_result)
    );

endmodule

@@ src/lpsm_ctrl.sv @@
// Sequencer for the linear probe slot map: sweep, probe and finish control.
// Depends on lpsm_pkg for state, command and status types.
module lpsm_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [1:0]                i_action,
    input  lpsm_pkg::t_dp_stat        i_stat,
    output lpsm_pkg::t_dp_cmd         o_cmd,
    output logic                      o_busy
);
    import lpsm_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_INIT: begin
                if (i_stat.sweep_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_start) begin
                    n_state = (i_action == ACT_CLEAR) ? ST_CLEAR : ST_READ;
                end
            end
            ST_READ: begin
                n_state = ST_CHECK;
            end
            ST_CHECK: begin
                if (i_stat.resolved || i_stat.last_probe) begin
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_READ;
                end
            end
            ST_CLEAR: begin
                if (i_stat.sweep_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_INIT;
            end
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        o_busy = 1'b1;
        case (r_state)
            ST_INIT: begin
                o_cmd.sweep = 1'b1;
            end
            ST_IDLE: begin
                o_busy     = 1'b0;
                o_cmd.load = i_start;
            end
            ST_READ: begin
            end
            ST_CHECK: begin
                if (i_stat.resolved || i_stat.last_probe) begin
                    o_cmd.finish = 1'b1;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            ST_CLEAR: begin
                o_cmd.sweep  = 1'b1;
                o_cmd.finish = i_stat.sweep_last;
            end
            default: begin
            end
        endcase
    end

endmodule

@@ src/lpsm_datapath.sv @@
// Datapath for the linear probe slot map: table memory, probe index,
// slot counter, limit register and result register. Depends on lpsm_pkg.
module lpsm_datapath #(
    parameter int TABLE_ENTRIES = lpsm_pkg::TABLE_ENTRIES_DEF,
    parameter int SLOT_LIMIT    = lpsm_pkg::SLOT_LIMIT_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  lpsm_pkg::t_in_item  i_item,
    input  logic                i_cfg_we,
    input  logic [12:0]         i_cfg_wdata,
    input  lpsm_pkg::t_dp_cmd   i_cmd,
    output lpsm_pkg::t_dp_stat  o_stat,
    output logic                o_strobe,
    output lpsm_pkg::t_out_item o_result
);
    import lpsm_pkg::*;

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam logic [IDX_W-1:0]   IDX_LAST = IDX_W'(TABLE_ENTRIES - 1);
    localparam logic [LIMIT_W-1:0] LIMIT_CAP = LIMIT_W'(SLOT_LIMIT);

    t_entry             r_mem [TABLE_ENTRIES];
    t_entry             r_rd;
    logic [IDX_W-1:0]   r_idx;
    logic [IDX_W-1:0]   n_idx;
    logic [IDX_W-1:0]   r_cnt;
    logic [IDX_W-1:0]   n_cnt;
    logic [KEY_W-1:0]   r_key;
    logic [ACT_W-1:0]   r_act;
    logic [USED_W-1:0]  r_used;
    logic [USED_W-1:0]  n_used;
    logic [USED_W-1:0]  r_max_slots;
    logic               r_strobe;
    t_out_item          r_result;
    t_out_item          n_result;

    logic               hit;
    logic               empty;
    logic               room;
    logic               mem_we;
    t_entry             mem_wdata;
    logic [LIMIT_W-1:0] max_ext;
    logic [LIMIT_W-1:0] limit;

    assign hit   = r_rd.valid && (r_rd.key == r_key);
    assign empty = !r_rd.valid;

    assign max_ext = LIMIT_W'(r_max_slots);
    assign limit   = (max_ext < LIMIT_CAP) ? max_ext : LIMIT_CAP;
    assign room    = LIMIT_W'(r_used) < limit;

    assign o_stat.resolved   = hit || empty;
    assign o_stat.last_probe = (r_cnt == IDX_LAST);
    assign o_stat.sweep_last = (r_idx == IDX_LAST);

    always_comb begin
        n_idx     = r_idx;
        n_cnt     = r_cnt;
        n_used    = r_used;
        n_result  = r_result;
        mem_we    = 1'b0;
        mem_wdata = '0;
        if (i_cmd.load) begin
            n_idx = (i_item.action == ACT_CLEAR) ? '0 : i_item.key[IDX_W-1:0];
            n_cnt = '0;
        end
        if (i_cmd.step) begin
            n_idx = r_idx + 1'b1;
            n_cnt = r_cnt + 1'b1;
        end
        if (i_cmd.sweep) begin
            mem_we = 1'b1;
            n_idx  = r_idx + 1'b1;
        end
        if (i_cmd.finish) begin
            n_result = '0;
            if (r_act == ACT_CLEAR) begin
                n_result.status = STAT_OK;
                n_used          = '0;
            end else if (!(hit || empty)) begin
                n_result.status = STAT_FULL;
            end else if (r_act == ACT_INSERT) begin
                if (hit) begin
                    n_result.status = STAT_PRESENT;
                end else if (room) begin
                    n_result.status = STAT_OK;
                    n_result.slot   = r_used[SLOT_W-1:0];
                    mem_we          = 1'b1;
                    mem_wdata.valid = 1'b1;
                    mem_wdata.key   = r_key;
                    mem_wdata.slot  = r_used[SLOT_W-1:0];
                    n_used          = r_used + 1'b1;
                end else begin
                    n_result.status = STAT_EXHAUSTED;
                end
            end else begin
                if (hit) begin
                    n_result.status = STAT_OK;
                    n_result.slot   = r_rd.slot;
                end else begin
                    n_result.status = STAT_ABSENT;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_idx] <= mem_wdata;
        end
        r_rd <= r_mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_used      <= '0;
            r_max_slots <= MAX_SLOTS_RESET;
            r_strobe    <= 1'b0;
        end else begin
            r_idx    <= n_idx;
            r_used   <= n_used;
            r_strobe <= i_cmd.finish;
            if (i_cfg_we) begin
                r_max_slots <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt    <= n_cnt;
        r_result <= n_result;
        if (i_cmd.load) begin
            r_key <= i_item.key;
            r_act <= i_item.action;
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

@@ src/lpsm_checker.sv @@
// Port-level assertions for the linear probe slot map, bound to the top level.
// Depends on lpsm_pkg and linear_probe_slot_map_defines.svh.
`include "linear_probe_slot_map_defines.svh"

module lpsm_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_start,
    input logic                i_busy,
    input logic                i_strobe,
    input lpsm_pkg::t_out_item i_result
);
    import lpsm_pkg::*;

    `LPSM_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, i_start && !i_busy, i_busy)
    `LPSM_ASSERT_NOW(a_strobe_after_busy, i_clk, i_rst_n, i_strobe, $past(i_busy) && !i_busy)
    `LPSM_ASSERT_NEXT(a_strobe_pulse, i_clk, i_rst_n, i_strobe, !i_strobe)
    `LPSM_ASSERT_NOW(a_slot_zero, i_clk, i_rst_n, i_strobe && (i_result.status != STAT_OK),
                     i_result.slot == '0)

endmodule

bind linear_probe_slot_map lpsm_checker u_lpsm_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_start  (start),
    .i_busy   (busy),
    .i_strobe (o_strobe),
    .i_result (o_result)
);

@@ tb/linear_probe_slot_map_test.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for linear_probe_slot_map: directed and random beats,
// checked against an in-bench model of the probing hash table.
// Depends on lpsm_pkg and the linear_probe_slot_map RTL.
module linear_probe_slot_map_test;
    import lpsm_pkg::*;

    localparam int TBL_SIZE       = TABLE_ENTRIES_DEF;
    localparam int SLOT_CAP       = SLOT_LIMIT_DEF;
    localparam int WATCHDOG_LIMIT = 60000;
    localparam int SETTLE_CYCLES  = 16;
    localparam int PHASE_BEATS    = 280;
    localparam int POOL_SIZE      = 64;
    localparam int CHAIN_LEN      = 16;
    localparam logic [ACT_W-1:0] ACT_SPARE = 2'd3;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    t_in_item            i_item;
    logic                i_cfg_we;
    logic [12:0]         i_cfg_wdata;
    logic                o_strobe;
    t_out_item           o_result;

    bit                  occupied [TBL_SIZE];
    logic [KEY_W-1:0]    held_key [TBL_SIZE];
    logic [SLOT_W-1:0]   held_slot [TBL_SIZE];
    logic [USED_W-1:0]   used_count = '0;
    logic [USED_W-1:0]   max_slots_cfg = MAX_SLOTS_RESET;

    t_out_item           pending_answers[$];
    int unsigned         mismatch_count = 0;
    int unsigned         idle_cycles = 0;
    bit                  no_idle = 1'b0;
    logic [KEY_W-1:0]    key_pool [POOL_SIZE];

    linear_probe_slot_map DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_strobe    (o_strobe),
        .o_result    (o_result)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_out_item map_predict(t_in_item it);
        t_out_item          r;
        logic [SLOT_W-1:0]  idx;
        int unsigned        step;
        bit                 found;
        int unsigned        lim;
        r = '0;
        lim = (max_slots_cfg < SLOT_CAP) ? max_slots_cfg : SLOT_CAP;
        if (it.action == ACT_CLEAR) begin
            foreach (occupied[i]) occupied[i] = 1'b0;
            used_count = '0;
            r.status = STAT_OK;
            return r;
        end
        found = 1'b0;
        idx = '0;
        for (step = 0; step < TBL_SIZE; step++) begin
            idx = it.key[SLOT_W-1:0] + step[SLOT_W-1:0];
            if (!occupied[idx] || held_key[idx] == it.key) begin
                found = 1'b1;
                break;
            end
        end
        if (!found) begin
            r.status = STAT_FULL;
        end else if (it.action == ACT_INSERT) begin
            if (occupied[idx]) begin
                r.status = STAT_PRESENT;
            end else if (used_count < lim) begin
                r.slot = used_count[SLOT_W-1:0];
                occupied[idx] = 1'b1;
                held_key[idx] = it.key;
                held_slot[idx] = r.slot;
                used_count = used_count + 1'b1;
                r.status = STAT_OK;
            end else begin
                r.status = STAT_EXHAUSTED;
            end
        end else begin
            if (occupied[idx]) begin
                r.slot = held_slot[idx];
                r.status = STAT_OK;
            end else begin
                r.status = STAT_ABSENT;
            end
        end
        return r;
    endfunction

    function automatic t_in_item make_beat(logic [ACT_W-1:0] act, logic [KEY_W-1:0] k);
        t_in_item b;
        b.action = act;
        b.key = k;
        return b;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic void refill_pool();
        logic [SLOT_W-1:0] base;
        logic [SLOT_W-1:0] home;
        logic [KEY_W-1:0]  upper;
        base = SLOT_W'($urandom_range(0, TBL_SIZE - 1));
        foreach (key_pool[i]) begin
            home = base + SLOT_W'($urandom_range(0, 40));
            upper = $urandom;
            key_pool[i] = {upper[KEY_W-1:SLOT_W], home};
        end
    endfunction

    function automatic void note_error(string msg);
        mismatch_count++;
        if (mismatch_count <= 10) $display("[%0t] mismatch: %s", $realtime, msg);
    endfunction

    task automatic send_beat(t_in_item it);
        int unsigned gap;
        start <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy !== 1'b0);
        pending_answers.push_back(map_predict(it));
        gap = pick_gap();
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_max_slots(logic [12:0] v);
        drain_results();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        max_slots_cfg = v;
    endtask

    task automatic test_basic_actions();
        send_beat(make_beat(ACT_LOOKUP, 32'h0000_0001));
        send_beat(make_beat(ACT_INSERT, 32'hFFFF_FFFF));
        send_beat(make_beat(ACT_INSERT, 32'h0000_0001));
        send_beat(make_beat(ACT_INSERT, 32'h0000_0000));
        send_beat(make_beat(ACT_LOOKUP, 32'h0000_0000));
        send_beat(make_beat(ACT_LOOKUP, 32'hFFFF_FFFF));
        send_beat(make_beat(ACT_INSERT, 32'h0000_0001));
        send_beat(make_beat(ACT_SPARE, 32'h0000_0001));
        send_beat(make_beat(ACT_INSERT, 32'h0001_0001));
        send_beat(make_beat(ACT_INSERT, 32'h0000_0FFF));
        send_beat(make_beat(ACT_LOOKUP, 32'h0001_0001));
        send_beat(make_beat(ACT_LOOKUP, 32'h0000_0FFF));
        send_beat(make_beat(ACT_LOOKUP, 32'hAAAA_5001));
        send_beat(make_beat(ACT_CLEAR, 32'h5555_AAAA));
        send_beat(make_beat(ACT_LOOKUP, 32'hFFFF_FFFF));
    endtask

    task automatic test_slot_limit();
        write_max_slots(13'd0);
        send_beat(make_beat(ACT_INSERT, 32'h1234_5678));
        send_beat(make_beat(ACT_LOOKUP, 32'h1234_5678));
        write_max_slots(13'd2);
        send_beat(make_beat(ACT_INSERT, 32'h1234_5678));
        send_beat(make_beat(ACT_INSERT, 32'h8765_4321));
        send_beat(make_beat(ACT_INSERT, 32'h0BAD_F00D));
        send_beat(make_beat(ACT_INSERT, 32'h1234_5678));
        send_beat(make_beat(ACT_LOOKUP, 32'h8765_4321));
        write_max_slots(13'd8191);
        send_beat(make_beat(ACT_INSERT, 32'h0BAD_F00D));
        send_beat(make_beat(ACT_CLEAR, 32'h0));
    endtask

    task automatic test_probe_wrap();
        logic [KEY_W-1:0] chain_keys [CHAIN_LEN];
        write_max_slots(13'd8191);
        for (int i = 0; i < CHAIN_LEN; i++) begin
            chain_keys[i] = {20'(i + 1), 12'hFFE};
            send_beat(make_beat(ACT_INSERT, chain_keys[i]));
        end
        for (int i = 0; i < CHAIN_LEN; i++) begin
            send_beat(make_beat(ACT_LOOKUP, chain_keys[i]));
        end
        send_beat(make_beat(ACT_LOOKUP, 32'hABCD_EFFE));
        send_beat(make_beat(ACT_INSERT, 32'h0000_5002));
        send_beat(make_beat(ACT_LOOKUP, 32'h0000_5002));
        send_beat(make_beat(ACT_INSERT, chain_keys[7]));
        send_beat(make_beat(ACT_CLEAR, 32'h0));
    endtask

    task automatic test_random_traffic();
        logic [12:0] limits [5] = '{13'd8191, 13'd60, 13'd4096, 13'd1, 13'd4095};
        int unsigned r;
        logic [KEY_W-1:0] k;
        for (int ph = 0; ph < 5; ph++) begin
            write_max_slots(limits[ph]);
            no_idle = (ph == 2);
            refill_pool();
            send_beat(make_beat(ACT_CLEAR, $urandom));
            for (int n = 0; n < PHASE_BEATS; n++) begin
                r = $urandom_range(0, 199);
                k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
                if (r < 90) begin
                    send_beat(make_beat(ACT_INSERT, k));
                end else if (r < 170) begin
                    send_beat(make_beat(ACT_LOOKUP, k));
                end else if (r < 180) begin
                    send_beat(make_beat(ACT_LOOKUP, $urandom));
                end else if (r < 188) begin
                    send_beat(make_beat(ACT_INSERT, $urandom));
                end else if (r < 198) begin
                    send_beat(make_beat(ACT_SPARE, k));
                end else begin
                    send_beat(make_beat(ACT_CLEAR, $urandom));
                    refill_pool();
                end
            end
        end
        no_idle = 1'b0;
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n === 1'b1 && o_strobe === 1'b1) begin
            if (pending_answers.size() == 0) begin
                note_error($sformatf("unexpected result slot=%0d status=%0d",
                                     o_result.slot, o_result.status));
            end else begin
                want = pending_answers.pop_front();
                if (o_result.slot !== want.slot || o_result.status !== want.status) begin
                    note_error($sformatf("slot exp %0d got %0d, status exp %0d got %0d",
                                         want.slot, o_result.slot,
                                         want.status, o_result.status));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n !== 1'b1 || (start && busy === 1'b0) || o_strobe === 1'b1) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        i_rst_n <= 1'b0;
        start <= 1'b0;
        i_item <= '0;
        i_cfg_we <= 1'b0;
        i_cfg_wdata <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_basic_actions();
        test_slot_limit();
        test_probe_wrap();
        test_random_traffic();
        drain_results();
        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
